[rtl/osic_pkg.sv]
// shared types and constants for the order sequence id checker
`default_nettype none

package osic_pkg;

	// id space
	localparam int SEQ_BITS  = 10;
	localparam int ID_DEPTH  = 1 << SEQ_BITS;
	localparam int CNT_BITS  = SEQ_BITS + 1;

	// order tag stored per bitmap entry; zero marks a scrubbed entry
	localparam int TAG_BITS = 8;
	localparam logic [TAG_BITS-1:0] TAG_FIRST = TAG_BITS'(1);
	localparam logic [TAG_BITS-1:0] TAG_LAST  = {TAG_BITS{1'b1}};
	localparam logic [TAG_BITS-1:0] TAG_CLEAR = '0;

	// result buffer
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS = RES_PTR_BITS + 1;

	// element kinds
	localparam logic [1:0] KIND_NODE = 2'd0;
	localparam logic [1:0] KIND_EDGE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	typedef enum logic [2:0] {
		V_OK        = 3'd0,
		V_EMPTY     = 3'd1,
		V_ODD_NODE  = 3'd2,
		V_EVEN_EDGE = 3'd3,
		V_DUP       = 3'd4,
		V_SKIP      = 3'd5,
		V_OVERLAP   = 3'd6,
		V_NO_BASE   = 3'd7
	} verdict_t;

	typedef struct packed {
		verdict_t              verdict;
		logic [SEQ_BITS-1:0]   bad_id;
		logic                  bad_edge;
	} res_t;

endpackage

`default_nettype wire

[rtl/order_sequence_id_checker.sv]
// order sequence id checker: bitmap read-modify-write pipeline and verdict buffer
//
// Input channel (elem_valid/elem_ready) takes one beat per element: kind, seq_id,
// released. Nodes and edges are checked against parity and a seen-id bitmap; an
// end-of-order beat produces one verdict beat on the result channel
// (res_valid/res_ready) with verdict, bad_seq_id and bad_on_edge. Kind three is
// taken and dropped.
// Throughput is one beat per cycle while elem_ready is high: the bitmap is one
// synchronous memory read in the accept cycle and written back in the next, with
// forwarding between the two. A verdict is registered into the buffer from stage
// one. The bitmap holds an order tag per id instead of a bit, so an order ends
// without clearing it. After reset, and after every 255th order when the tag wraps,
// a scrub pass writes all 1024 entries, one per cycle; elem_ready is low throughout
// the pass, and at a tag wrap also while the last end beat drains. Verdicts queue
// in a four-beat buffer. When the receiver stalls, elements still flow; elem_ready
// drops only when the buffer cannot take a further verdict. Reset (arst_n low)
// empties the pipeline and buffer and restarts the order state.
`default_nettype none

module order_sequence_id_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          elem_valid,
	output logic                         elem_ready,
	input  wire [1:0]                    kind,
	input  wire [osic_pkg::SEQ_BITS-1:0] seq_id,
	input  wire                          released,
	output logic                         res_valid,
	input  wire                          res_ready,
	output osic_pkg::verdict_t           verdict,
	output logic [osic_pkg::SEQ_BITS-1:0] bad_seq_id,
	output logic                         bad_on_edge
);
	import osic_pkg::*;

	// bitmap memory
	logic [TAG_BITS-1:0] seen_mem [ID_DEPTH];
	logic [TAG_BITS-1:0] map_rdata_s1;
	logic                map_we;
	logic [SEQ_BITS-1:0] map_waddr;
	logic [TAG_BITS-1:0] map_wdata;

	// stage one
	logic                v_s1;
	logic                end_s1;
	logic                edge_s1;
	logic                rel_s1;
	logic [SEQ_BITS-1:0] id_s1;
	logic                fwd_s1;

	// scrub and tag
	logic                clear_q;
	logic [SEQ_BITS-1:0] clr_addr_q;
	logic [TAG_BITS-1:0] epoch_q;

	// order state
	verdict_t            first_err_q;
	logic [SEQ_BITS-1:0] err_id_q;
	logic                err_edge_q;
	logic                any_node_q;
	logic [CNT_BITS-1:0] elem_cnt_q;
	logic [SEQ_BITS-1:0] lowest_q;
	logic [SEQ_BITS-1:0] highest_q;
	logic                base_seen_q;
	logic [SEQ_BITS-1:0] base_high_q;
	logic                hor_seen_q;
	logic [SEQ_BITS-1:0] hor_low_q;

	// verdict buffer
	res_t                    res_mem_q [RES_DEPTH];
	logic [RES_PTR_BITS-1:0] res_wr_q;
	logic [RES_PTR_BITS-1:0] res_rd_q;
	logic [RES_CNT_BITS-1:0] res_cnt_q;

	logic     in_acc;
	logic     is_elem;
	logic     wrap_pend;
	logic     elem_s1;
	logic     end_go;
	logic     seen;
	logic     odd_node;
	logic     even_edge;
	logic     take;
	logic     res_push;
	logic     res_pop;
	logic [CNT_BITS-1:0] span;
	res_t     res_new;
	verdict_t v_new;

	// input handshake
	assign wrap_pend  = v_s1 && end_s1 && (epoch_q == TAG_LAST);
	assign elem_ready = !clear_q && !wrap_pend &&
		((res_cnt_q + RES_CNT_BITS'(v_s1 && end_s1)) < RES_CNT_BITS'(RES_DEPTH));
	assign in_acc     = elem_valid && elem_ready;
	assign is_elem    = (kind == KIND_NODE) || (kind == KIND_EDGE);

	// stage one decode
	assign elem_s1   = v_s1 && !end_s1;
	assign end_go    = v_s1 && end_s1;
	assign seen      = fwd_s1 || (map_rdata_s1 == epoch_q);
	assign odd_node  = !edge_s1 && id_s1[0];
	assign even_edge = edge_s1 && !id_s1[0];
	assign take      = elem_s1 && (first_err_q == V_OK) && !odd_node && !even_edge && !seen;

	// bitmap write port: scrub or stamp
	always_comb begin
		map_we    = clear_q || take;
		map_waddr = clear_q ? clr_addr_q : id_s1;
		map_wdata = clear_q ? TAG_CLEAR : epoch_q;
	end

	// bitmap memory, read-before-write
	always_ff @(posedge clk) begin
		if (map_we) begin
			seen_mem[map_waddr] <= map_wdata;
		end
		if (in_acc) begin
			map_rdata_s1 <= seen_mem[seq_id];
		end
	end

	// stage one pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc && (is_elem || (kind == KIND_END));
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			end_s1  <= (kind == KIND_END);
			edge_s1 <= (kind == KIND_EDGE);
			rel_s1  <= released;
			id_s1   <= seq_id;
			fwd_s1  <= take && (id_s1 == seq_id);
		end
	end

	// verdict selection
	assign span = CNT_BITS'(highest_q) - CNT_BITS'(lowest_q) + CNT_BITS'(1);

	always_comb begin
		res_new.bad_id   = '0;
		res_new.bad_edge = 1'b0;
		if (!any_node_q) begin
			v_new = V_EMPTY;
		end else if (first_err_q != V_OK) begin
			v_new            = first_err_q;
			res_new.bad_id   = err_id_q;
			res_new.bad_edge = err_edge_q;
		end else if (!base_seen_q) begin
			v_new = V_NO_BASE;
		end else if (span != elem_cnt_q) begin
			v_new = V_SKIP;
		end else if (hor_seen_q &&
			(CNT_BITS'(hor_low_q) != CNT_BITS'(base_high_q) + CNT_BITS'(1))) begin
			v_new = V_OVERLAP;
		end else begin
			v_new = V_OK;
		end
		res_new.verdict = v_new;
	end

	// order state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_err_q <= V_OK;
			err_id_q    <= '0;
			err_edge_q  <= 1'b0;
			any_node_q  <= 1'b0;
			elem_cnt_q  <= '0;
			lowest_q    <= '1;
			highest_q   <= '0;
			base_seen_q <= 1'b0;
			base_high_q <= '0;
			hor_seen_q  <= 1'b0;
			hor_low_q   <= '1;
		end else if (end_go) begin
			first_err_q <= V_OK;
			err_id_q    <= '0;
			err_edge_q  <= 1'b0;
			any_node_q  <= 1'b0;
			elem_cnt_q  <= '0;
			lowest_q    <= '1;
			highest_q   <= '0;
			base_seen_q <= 1'b0;
			base_high_q <= '0;
			hor_seen_q  <= 1'b0;
			hor_low_q   <= '1;
		end else if (elem_s1) begin
			if (!edge_s1) begin
				any_node_q <= 1'b1;
			end
			if (first_err_q == V_OK) begin
				if (odd_node) begin
					first_err_q <= V_ODD_NODE;
					err_id_q    <= id_s1;
					err_edge_q  <= 1'b0;
				end else if (even_edge) begin
					first_err_q <= V_EVEN_EDGE;
					err_id_q    <= id_s1;
					err_edge_q  <= 1'b1;
				end else if (seen) begin
					first_err_q <= V_DUP;
					err_id_q    <= id_s1;
					err_edge_q  <= edge_s1;
				end else begin
					elem_cnt_q <= elem_cnt_q + CNT_BITS'(1);
					if (id_s1 < lowest_q) begin
						lowest_q <= id_s1;
					end
					if (id_s1 > highest_q) begin
						highest_q <= id_s1;
					end
					if (rel_s1) begin
						base_seen_q <= 1'b1;
						if (id_s1 > base_high_q) begin
							base_high_q <= id_s1;
						end
					end else begin
						hor_seen_q <= 1'b1;
						if (id_s1 < hor_low_q) begin
							hor_low_q <= id_s1;
						end
					end
				end
			end
		end
	end

	// order tag and scrub pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
			epoch_q    <= TAG_FIRST;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + SEQ_BITS'(1);
			if (clr_addr_q == {SEQ_BITS{1'b1}}) begin
				clear_q <= 1'b0;
			end
		end else if (end_go) begin
			if (epoch_q == TAG_LAST) begin
				clear_q    <= 1'b1;
				clr_addr_q <= '0;
				epoch_q    <= TAG_FIRST;
			end else begin
				epoch_q <= epoch_q + TAG_BITS'(1);
			end
		end
	end

	// verdict buffer
	assign res_push = end_go;
	assign res_pop  = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= res_wr_q + RES_PTR_BITS'(1);
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + RES_PTR_BITS'(1);
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + RES_CNT_BITS'(1);
			end else if (res_pop && !res_push) begin
				res_cnt_q <= res_cnt_q - RES_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= res_new;
		end
	end

	// result beat
	assign res_valid   = (res_cnt_q != '0);
	assign verdict     = res_mem_q[res_rd_q].verdict;
	assign bad_seq_id  = res_mem_q[res_rd_q].bad_id;
	assign bad_on_edge = res_mem_q[res_rd_q].bad_edge;

`ifndef SYNTH
	// no element in flight while the bitmap is being scrubbed
	a_no_elem_in_scrub: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !v_s1)
		else $error("element in flight during scrub");

	// buffer never overfills
	a_res_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= RES_CNT_BITS'(RES_DEPTH))
		else $error("verdict buffer overflow");

	// end of the last tagged order starts a scrub pass
	a_wrap_scrub: assert property (@(posedge clk) disable iff (!arst_n)
		(end_go && (epoch_q == TAG_LAST)) |=> clear_q)
		else $error("tag wrap without scrub");

	// tag never takes the scrubbed value
	a_tag_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != TAG_CLEAR)
		else $error("order tag is zero");

	// only element errors carry an offending id
	a_bad_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (verdict == V_OK || verdict == V_EMPTY || verdict == V_SKIP ||
		verdict == V_OVERLAP || verdict == V_NO_BASE))
		|-> (bad_seq_id == '0 && !bad_on_edge))
		else $error("offending id on non-element verdict");
`endif

endmodule

`default_nettype wire

[tb/order_sequence_id_checker_tb.sv]
// self-checking testbench for the order sequence id checker
`timescale 1ns / 1ps

module order_sequence_id_checker_tb;
	import osic_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int RAND_END    = 680;
	localparam int QUIET_FROM  = 600;
	localparam int SHORT_RUNS  = 250;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]          kind;
		logic [SEQ_BITS-1:0] id;
		logic                rel;
	} elem_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_DUP,
		FLAW_PARITY,
		FLAW_SKIP,
		FLAW_OVERLAP,
		FLAW_NO_BASE,
		FLAW_NO_NODE,
		FLAW_NOISE
	} flaw_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                elem_valid;
	logic                elem_ready;
	logic [1:0]          kind;
	logic [SEQ_BITS-1:0] seq_id;
	logic                released;
	logic                res_valid;
	logic                res_ready;
	verdict_t            verdict;
	logic [SEQ_BITS-1:0] bad_seq_id;
	logic                bad_on_edge;

	// order state mirrored from the block
	bit [ID_DEPTH-1:0]   seen_ids;
	verdict_t            first_fault;
	logic [SEQ_BITS-1:0] fault_id;
	logic                fault_on_edge;
	bit                  has_node;
	int                  taken_count;
	logic [SEQ_BITS-1:0] low_id;
	logic [SEQ_BITS-1:0] high_id;
	bit                  has_base;
	logic [SEQ_BITS-1:0] base_top;
	bit                  has_horizon;
	logic [SEQ_BITS-1:0] horizon_bottom;

	res_t verdict_q[$];
	bit   idle_en = 1'b0;
	int   stall_left = 0;
	int   err_count = 0;
	int   elem_beats = 0;
	int   spare_beats = 0;
	int   orders_sent = 0;
	int   clean_seen = 0;
	int   cyc = 0;

	order_sequence_id_checker i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.elem_valid  (elem_valid),
		.elem_ready  (elem_ready),
		.kind        (kind),
		.seq_id      (seq_id),
		.released    (released),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.verdict     (verdict),
		.bad_seq_id  (bad_seq_id),
		.bad_on_edge (bad_on_edge)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// back to the empty order
	function automatic void clear_order();
		seen_ids       = '0;
		first_fault    = V_OK;
		fault_id       = '0;
		fault_on_edge  = 1'b0;
		has_node       = 1'b0;
		taken_count    = 0;
		low_id         = '1;
		high_id        = '0;
		has_base       = 1'b0;
		base_top       = '0;
		has_horizon    = 1'b0;
		horizon_bottom = '1;
	endfunction

	function automatic void record_fault(verdict_t code, logic [SEQ_BITS-1:0] id, logic on_edge);
		first_fault   = code;
		fault_id      = id;
		fault_on_edge = on_edge;
	endfunction

	// verdict for the order collected so far, in priority order
	function automatic res_t judge_order();
		res_t r;
		r.verdict  = V_OK;
		r.bad_id   = '0;
		r.bad_edge = 1'b0;
		if (!has_node) begin
			r.verdict = V_EMPTY;
		end else if (first_fault != V_OK) begin
			r.verdict  = first_fault;
			r.bad_id   = fault_id;
			r.bad_edge = fault_on_edge;
		end else if (!has_base) begin
			r.verdict = V_NO_BASE;
		end else if (int'(high_id) - int'(low_id) + 1 != taken_count) begin
			r.verdict = V_SKIP;
		end else if (has_horizon && int'(horizon_bottom) != int'(base_top) + 1) begin
			r.verdict = V_OVERLAP;
		end
		return r;
	endfunction

	// update the mirrored order state with one accepted beat
	function automatic void track_beat(elem_t e);
		logic on_edge;
		on_edge = (e.kind == KIND_EDGE);
		case (e.kind)
			KIND_NODE, KIND_EDGE: begin
				elem_beats++;
				if (!on_edge)
					has_node = 1'b1;
				if (first_fault != V_OK) begin
					// later elements only mark the node flag
				end else if (!on_edge && e.id[0]) begin
					record_fault(V_ODD_NODE, e.id, 1'b0);
				end else if (on_edge && !e.id[0]) begin
					record_fault(V_EVEN_EDGE, e.id, 1'b1);
				end else if (seen_ids[e.id]) begin
					record_fault(V_DUP, e.id, on_edge);
				end else begin
					seen_ids[e.id] = 1'b1;
					taken_count++;
					if (e.id < low_id)
						low_id = e.id;
					if (e.id > high_id)
						high_id = e.id;
					if (e.rel) begin
						has_base = 1'b1;
						if (e.id > base_top)
							base_top = e.id;
					end else begin
						has_horizon = 1'b1;
						if (e.id < horizon_bottom)
							horizon_bottom = e.id;
					end
				end
			end
			KIND_END: begin
				elem_beats++;
				orders_sent++;
				verdict_q.push_back(judge_order());
				clear_order();
			end
			default: begin
				spare_beats++;
			end
		endcase
	endfunction

	// one beat on the element channel, with an optional idle burst ahead of it
	task automatic send_beat(elem_t e);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			elem_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		elem_valid <= 1'b1;
		kind       <= e.kind;
		seq_id     <= e.id;
		released   <= e.rel;
		do
			@(posedge clk);
		while (!elem_ready);
		track_beat(e);
	endtask

	task automatic send_beat_of(logic [1:0] k, int id, logic rel);
		send_beat(elem_t'{k, SEQ_BITS'(id), rel});
	endtask

	// end marker with random content in the ignored fields
	task automatic send_end();
		send_beat_of(KIND_END, $urandom_range(0, ID_DEPTH - 1), 1'($urandom_range(0, 1)));
	endtask

	// random node, edge or spare beat; ids often drawn from a small pool to force reuse
	task automatic send_random_beat(bit allow_spare);
		int pick;
		int id;
		pick = $urandom_range(0, allow_spare ? 2 : 1);
		id   = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, ID_DEPTH - 1);
		send_beat_of(pick == 2 ? KIND_SPARE : 2'(pick), id, 1'($urandom_range(0, 1)));
	endtask

	// orders with no node at all
	task automatic test_empty_orders();
		send_beat_of(KIND_END, ID_DEPTH - 1, 1'b1);
		send_beat_of(KIND_EDGE, 1, 1'b1);
		send_end();
	endtask

	// clean orders at both ends of the id space, with a spare beat in between
	task automatic test_clean_extremes();
		send_beat_of(KIND_NODE, 0, 1'b1);
		send_beat_of(KIND_EDGE, 1, 1'b1);
		send_beat_of(KIND_NODE, 2, 1'b0);
		send_end();
		send_beat_of(KIND_NODE, ID_DEPTH - 2, 1'b1);
		send_beat_of(KIND_SPARE, ID_DEPTH - 1, 1'b1);
		send_beat_of(KIND_EDGE, ID_DEPTH - 1, 1'b0);
		send_end();
	endtask

	// odd node, and an even edge followed by a node after the fault
	task automatic test_parity_faults();
		send_beat_of(KIND_NODE, ID_DEPTH - 1, 1'b1);
		send_beat_of(KIND_EDGE, 0, 1'b0);
		send_end();
		send_beat_of(KIND_EDGE, 2, 1'b1);
		send_beat_of(KIND_NODE, 5, 1'b1);
		send_end();
	endtask

	task automatic test_duplicate_id();
		send_beat_of(KIND_NODE, 8, 1'b1);
		send_beat_of(KIND_NODE, 8, 1'b1);
		send_end();
	endtask

	// gap in the ids, base above horizon, and no released element
	task automatic test_split_faults();
		send_beat_of(KIND_NODE, 0, 1'b1);
		send_beat_of(KIND_NODE, 4, 1'b1);
		send_end();
		send_beat_of(KIND_NODE, 2, 1'b0);
		send_beat_of(KIND_EDGE, 3, 1'b1);
		send_beat_of(KIND_NODE, 4, 1'b1);
		send_end();
		send_beat_of(KIND_NODE, 6, 1'b0);
		send_end();
	endtask

	// many tiny orders, enough to run the order tag through a full wrap
	task automatic test_short_orders(int count);
		int shape;
		repeat (count) begin
			idle_en = ($urandom_range(0, 2) != 0);
			shape = $urandom_range(0, 9);
			if (shape == 2)
				send_beat_of(KIND_SPARE, $urandom_range(0, ID_DEPTH - 1),
					1'($urandom_range(0, 1)));
			if (shape >= 3)
				send_random_beat(1'b0);
			if (shape >= 8)
				send_random_beat(1'b0);
			send_end();
		end
	endtask

	// well-formed orders with random placement, size and release split, some damaged
	task automatic test_shaped_orders();
		elem_t ord[$];
		elem_t tmp;
		flaw_t flaw;
		int n;
		int span;
		int start;
		int rel_len;
		int pick;
		int j;
		int k;
		while (elem_beats < RAND_END) begin
			idle_en = (elem_beats < QUIET_FROM) && ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 19);
			if (pick < 14)
				n = $urandom_range(1, 4);
			else if (pick < 19)
				n = $urandom_range(5, 16);
			else
				n = $urandom_range(17, 64);
			span    = 2 * n - 1;
			start   = 2 * $urandom_range(0, (ID_DEPTH - span) / 2);
			rel_len = $urandom_range(1, span);
			ord.delete();
			for (j = 0; j < n; j++)
				ord.push_back(elem_t'{KIND_NODE, SEQ_BITS'(start + 2 * j), 2 * j < rel_len});
			for (j = 0; j < n - 1; j++)
				ord.push_back(elem_t'{KIND_EDGE, SEQ_BITS'(start + 2 * j + 1),
					2 * j + 1 < rel_len});

			if ($urandom_range(0, 9) < 4)
				flaw = FLAW_NONE;
			else
				flaw = flaw_t'($urandom_range(FLAW_DUP, FLAW_NOISE));
			case (flaw)
				FLAW_DUP: begin
					tmp = ord[$urandom_range(0, ord.size() - 1)];
					ord.insert($urandom_range(0, ord.size()), tmp);
				end
				FLAW_PARITY: begin
					j = $urandom_range(0, ord.size() - 1);
					ord[j].id[0] = ~ord[j].id[0];
				end
				FLAW_SKIP: begin
					// drop an id from the inside of the range
					if (span >= 3) begin
						k = $urandom_range(1, span - 2);
						ord.delete(k[0] ? n + (k - 1) / 2 : k / 2);
					end
				end
				FLAW_OVERLAP: begin
					j = $urandom_range(0, ord.size() - 1);
					ord[j].rel = ~ord[j].rel;
				end
				FLAW_NO_BASE: begin
					foreach (ord[j])
						ord[j].rel = 1'b0;
				end
				FLAW_NO_NODE: begin
					repeat (n)
						void'(ord.pop_front());
				end
				FLAW_NOISE: begin
					repeat ($urandom_range(1, 3)) begin
						pick = $urandom_range(0, 2);
						tmp  = elem_t'{pick == 2 ? KIND_SPARE : 2'(pick),
							SEQ_BITS'($urandom_range(0, ID_DEPTH - 1)),
							1'($urandom_range(0, 1))};
						ord.insert($urandom_range(0, ord.size()), tmp);
					end
				end
				default: begin
				end
			endcase

			// arrival order is free, so sometimes mix nodes and edges
			if ($urandom_range(0, 7) == 0) begin
				foreach (ord[j]) begin
					k      = $urandom_range(0, ord.size() - 1);
					tmp    = ord[j];
					ord[j] = ord[k];
					ord[k] = tmp;
				end
			end

			foreach (ord[j])
				send_beat(ord[j]);
			send_end();
		end
	endtask

	// receiver stalls in bursts of random length while idle_en is set
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			res_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			res_ready <= 1'b1;
		end
	end

	// compare every verdict beat against the oldest prediction
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected verdict beat: verdict %0d bad_seq_id %0d bad_on_edge %0d",
					$time, verdict, bad_seq_id, bad_on_edge);
				err_count++;
			end else begin
				want = verdict_q.pop_front();
				if (verdict === V_OK)
					clean_seen++;
				if (verdict !== want.verdict) begin
					$display("%0t: verdict expected %0d got %0d", $time, want.verdict, verdict);
					err_count++;
				end
				if (bad_seq_id !== want.bad_id) begin
					$display("%0t: bad_seq_id expected %0d got %0d",
						$time, want.bad_id, bad_seq_id);
					err_count++;
				end
				if (bad_on_edge !== want.bad_edge) begin
					$display("%0t: bad_on_edge expected %0d got %0d",
						$time, want.bad_edge, bad_on_edge);
					err_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("timeout after %0d cycles, %0d verdicts outstanding", cyc, verdict_q.size());
		$display("TB_ERROR");
		$finish;
	end

	// main sequence
	initial begin
		arst_n     <= 1'b0;
		elem_valid <= 1'b0;
		kind       <= KIND_NODE;
		seq_id     <= '0;
		released   <= 1'b0;
		res_ready  <= 1'b0;
		clear_order();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		idle_en = 1'b1;
		test_empty_orders();
		test_clean_extremes();
		test_parity_faults();
		test_duplicate_id();
		test_split_faults();
		test_short_orders(SHORT_RUNS);
		test_shaped_orders();

		idle_en = 1'b0;
		elem_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d orders (%0d clean) from %0d element beats and %0d spare beats",
			orders_sent, clean_seen, elem_beats, spare_beats);
		$display("%0d mismatches over %0d cycles", err_count, cyc);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/osic_pkg.sv
rtl/order_sequence_id_checker.sv
tb/order_sequence_id_checker_tb.sv
